/* hw/rtl/tps_pkg.sv */
`default_nettype none

package tps_pkg;

    localparam int COORD_W   = 16;
    localparam int SLOT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Slot compare width: covers the largest storage depth (64) plus one.
    localparam int SLOT_CMP_W = 7;

    // Item queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_DEN = 2'd1;

    // Item classes decided by the front
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PASS   = 2'd0;  // invalid or out-of-range slot
    localparam kind_t KIND_PEN_UP = 2'd1;  // valid, zero pressure
    localparam kind_t KIND_PRESS  = 2'd2;  // valid, pressed

    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  pressure;
        logic                sample_valid;
    } item_t;

    // Effective blend weights: den never zero, num never above den
    typedef struct packed {
        logic [COORD_W-1:0] num;
        logic [COORD_W-1:0] den;
    } weights_t;

endpackage

`default_nettype wire

/* hw/rtl/tps_if.sv */
`default_nettype none

interface tps_in_if;
    logic                             valid;
    logic                             ready;
    logic [tps_pkg::SLOT_W-1:0]       slot;
    logic [tps_pkg::COORD_W-1:0]      x_in;
    logic [tps_pkg::COORD_W-1:0]      y_in;
    logic [tps_pkg::COORD_W-1:0]      pressure_in;
    logic                             sample_valid;

    modport source (output valid, slot, x_in, y_in, pressure_in, sample_valid, input ready);
    modport sink   (input valid, slot, x_in, y_in, pressure_in, sample_valid, output ready);
endinterface

interface tps_out_if;
    logic                             valid;
    logic                             ready;
    logic [tps_pkg::SLOT_W-1:0]       slot_out;
    logic [tps_pkg::COORD_W-1:0]      x_out;
    logic [tps_pkg::COORD_W-1:0]      y_out;
    logic [tps_pkg::COORD_W-1:0]      pressure_out;
    logic                             valid_out;

    modport source (output valid, slot_out, x_out, y_out, pressure_out, valid_out, input ready);
    modport sink   (input valid, slot_out, x_out, y_out, pressure_out, valid_out, output ready);
endinterface

interface tps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tps_pkg::CFG_IDX_W-1:0]      index;
    logic [tps_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tps_front.sv */
`default_nettype none

// Input stage: registers one sample and tags it with its class.
module tps_front #(
    parameter int SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [tps_pkg::SLOT_W-1:0]    in_slot,
    input  wire logic [tps_pkg::COORD_W-1:0]   in_x,
    input  wire logic [tps_pkg::COORD_W-1:0]   in_y,
    input  wire logic [tps_pkg::COORD_W-1:0]   in_pressure,
    input  wire logic                          in_sample_valid,
    output      logic                          push_valid,
    input  wire logic                          push_ready,
    output      tps_pkg::item_t                push_item
);

    localparam int CMP_W = tps_pkg::SLOT_CMP_W;

    logic           fr_valid_reg, fr_valid_next;
    tps_pkg::item_t item_reg, item_next;
    logic           in_range;
    logic           in_fire;

    assign in_range   = {{(CMP_W - tps_pkg::SLOT_W){1'b0}}, in_slot} < CMP_W'(SLOTS);
    assign in_ready   = !fr_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = fr_valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        item_next              = item_reg;
        fr_valid_next          = fr_valid_reg;
        if (push_ready)
        begin
            fr_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            fr_valid_next          = 1'b1;
            item_next.slot         = in_slot;
            item_next.x            = in_x;
            item_next.y            = in_y;
            item_next.pressure     = in_pressure;
            item_next.sample_valid = in_sample_valid;
            if (!in_sample_valid || !in_range)
            begin
                item_next.kind = tps_pkg::KIND_PASS;
            end
            else if (in_pressure == '0)
            begin
                item_next.kind = tps_pkg::KIND_PEN_UP;
            end
            else
            begin
                item_next.kind = tps_pkg::KIND_PRESS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/tps_fifo.sv */
`default_nettype none

// Short item queue decoupling the front from the back.
module tps_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output      logic           push_ready,
    input  wire tps_pkg::item_t push_item,
    output      logic           pop_valid,
    input  wire logic           pop_ready,
    output      tps_pkg::item_t pop_item
);

    localparam int PTR_W = tps_pkg::FIFO_PTR_W;
    localparam int CNT_W = tps_pkg::FIFO_CNT_W;

    tps_pkg::item_t         entry_mem [tps_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   push_fire, pop_fire;

    assign push_ready = count_reg != CNT_W'(tps_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_fire  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tps_back.sv */
`default_nettype none

// Execution side: per-slot state, blend datapath and output register.
// Blend: one multiply per cycle, then a 16-step restoring divider, x then y.
module tps_back #(
    parameter int SLOTS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tps_pkg::weights_t             weights,
    input  wire logic                          pop_valid,
    output      logic                          pop_ready,
    input  wire tps_pkg::item_t                pop_item,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [tps_pkg::SLOT_W-1:0]    out_slot,
    output      logic [tps_pkg::COORD_W-1:0]   out_x,
    output      logic [tps_pkg::COORD_W-1:0]   out_y,
    output      logic [tps_pkg::COORD_W-1:0]   out_pressure,
    output      logic                          out_sample_valid
);

    localparam int CW     = tps_pkg::COORD_W;
    localparam int ACC_W  = 2 * CW;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W  = tps_pkg::SLOT_CMP_W;
    localparam int CNT_W  = $clog2(CW);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(CW - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MUL_A = 3'd2;
    localparam logic [2:0] ST_MUL_B = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [CW-1:0]       smooth_x_mem [SLOTS];
    logic [CW-1:0]       smooth_y_mem [SLOTS];
    logic [SLOTS-1:0]    pen_active_reg, pen_active_next;

    logic [2:0]          state_reg, state_next;
    tps_pkg::item_t      item_reg, item_next;
    logic [CW-1:0]       old_x_reg, old_y_reg;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                axis_reg, axis_next;
    logic [CW-1:0]       res_x_reg, res_x_next;
    logic [CW-1:0]       res_y_reg, res_y_next;
    logic                wr_pending_reg, wr_pending_next;
    logic                act_we_reg, act_we_next;
    logic                act_val_reg, act_val_next;

    logic                out_valid_reg, out_valid_next;
    logic [tps_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CW-1:0]       out_x_reg, out_x_next;
    logic [CW-1:0]       out_y_reg, out_y_next;
    logic [CW-1:0]       out_p_reg, out_p_next;
    logic                out_sv_reg, out_sv_next;

    logic [CMP_W-1:0]    rd_slot_w, wr_slot_w;
    logic [IDX_W-1:0]    rd_idx, wr_idx;
    logic                mem_re, mem_we, out_free;
    logic [CW-1:0]       mul_old, mul_fresh, half_den;
    logic [ACC_W-1:0]    prod_a, prod_b;
    logic [CW:0]         trial, trial_sub;
    logic                q_bit;
    logic [CW-1:0]       new_rem, quotient;

    assign rd_slot_w = {{(CMP_W - tps_pkg::SLOT_W){1'b0}}, pop_item.slot};
    assign wr_slot_w = {{(CMP_W - tps_pkg::SLOT_W){1'b0}}, item_reg.slot};
    assign rd_idx    = rd_slot_w[IDX_W-1:0];
    assign wr_idx    = wr_slot_w[IDX_W-1:0];

    assign pop_ready = state_reg == ST_IDLE;
    assign mem_re    = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign mem_we    = (state_reg == ST_DONE) && out_free && wr_pending_reg;

    assign mul_old   = axis_reg ? old_y_reg : old_x_reg;
    assign mul_fresh = axis_reg ? item_reg.y : item_reg.x;
    assign half_den  = weights.den >> 1;
    assign prod_a    = weights.num * mul_old;
    assign prod_b    = (weights.den - weights.num) * mul_fresh;

    // acc holds remainder in the upper half, dividend/quotient bits below
    assign trial     = {acc_reg[ACC_W-1:CW], acc_reg[CW-1]};
    assign trial_sub = trial - {1'b0, weights.den};
    assign q_bit     = trial >= {1'b0, weights.den};
    assign new_rem   = q_bit ? trial_sub[CW-1:0] : trial[CW-1:0];
    assign quotient  = {acc_reg[CW-2:0], q_bit};

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        axis_next       = axis_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        wr_pending_next = wr_pending_reg;
        act_we_next     = act_we_reg;
        act_val_next    = act_val_reg;
        pen_active_next = pen_active_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        out_slot_next   = out_slot_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_p_next      = out_p_reg;
        out_sv_next     = out_sv_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    item_next  = pop_item;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                res_x_next      = item_reg.x;
                res_y_next      = item_reg.y;
                axis_next       = 1'b0;
                wr_pending_next = 1'b0;
                act_we_next     = 1'b0;
                act_val_next    = 1'b0;
                state_next      = ST_DONE;
                case (item_reg.kind)
                    tps_pkg::KIND_PEN_UP:
                    begin
                        wr_pending_next = 1'b1;
                        act_we_next     = 1'b1;
                    end
                    tps_pkg::KIND_PRESS:
                    begin
                        wr_pending_next = 1'b1;
                        if (pen_active_reg[wr_idx])
                        begin
                            state_next = ST_MUL_A;
                        end
                        else
                        begin
                            act_we_next  = 1'b1;
                            act_val_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MUL_A:
            begin
                acc_next   = prod_a + {{CW{1'b0}}, half_den};
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                // sum stays below den * 2^16, so quotient fits 16 bits
                acc_next   = acc_reg + prod_b;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                acc_next = {new_rem, quotient};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    if (!axis_reg)
                    begin
                        res_x_next = quotient;
                        axis_next  = 1'b1;
                        state_next = ST_MUL_A;
                    end
                    else
                    begin
                        res_y_next = quotient;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = item_reg.slot;
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_p_next     = item_reg.pressure;
                    out_sv_next    = item_reg.sample_valid;
                    if (act_we_reg)
                    begin
                        pen_active_next[wr_idx] = act_val_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pen_active_reg <= '0;
            out_valid_reg  <= 1'b0;
            wr_pending_reg <= 1'b0;
            act_we_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pen_active_reg <= pen_active_next;
            out_valid_reg  <= out_valid_next;
            wr_pending_reg <= wr_pending_next;
            act_we_reg     <= act_we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        axis_reg     <= axis_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        act_val_reg  <= act_val_next;
        out_slot_reg <= out_slot_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_p_reg    <= out_p_next;
        out_sv_reg   <= out_sv_next;
    end

    // Smoothed point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            smooth_x_mem[wr_idx] <= res_x_reg;
            smooth_y_mem[wr_idx] <= res_y_reg;
        end
        if (mem_re)
        begin
            old_x_reg <= smooth_x_mem[rd_idx];
            old_y_reg <= smooth_y_mem[rd_idx];
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_slot         = out_slot_reg;
    assign out_x            = out_x_reg;
    assign out_y            = out_y_reg;
    assign out_pressure     = out_p_reg;
    assign out_sample_valid = out_sv_reg;

endmodule

`default_nettype wire

/* hw/rtl/touch_point_iir_smoother_core.sv */
// Touch point smoother: first-order IIR smoothing of x/y per contact slot.
// Channels:
//   in_ch  - one touch sample per transfer (slot, x, y, pressure, valid flag).
//   out_ch - exactly one result per input transfer, in input order.
//   cfg_ch - register writes: index 0 smoothing numerator, index 1
//            denominator; other indexes are dropped. Always ready; write
//            only while no sample is in flight.
// Each sample passes the input register, the queue, the back-end slot
//   lookup and the output register; a blended sample also passes the blend.
// Back end: it handles one item at a time. A blended sample goes through
//   slot lookup, then per axis the multiply states MUL_A and MUL_B and
//   the shared restoring divider. Other samples go from slot lookup
//   straight to the output register.
// A two-entry queue sits between the input register and the back end, so
//   the input keeps taking samples while a result waits on a stalled
//   receiver; when the queue and the input register fill, in_ch.ready drops.
// Reset: clears all pen-active flags and the queue, numerator to 0,
//   denominator to 1. Stored points need no clearing; they are used only
//   after a pen-down sample has written them.
`default_nettype none

module touch_point_iir_smoother_core #(
    parameter int SLOTS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tps_in_if.sink       in_ch,
    tps_out_if.source    out_ch,
    tps_cfg_if.sink      cfg_ch
);

    // Configuration registers
    logic [tps_pkg::CFG_DATA_W-1:0] num_reg, num_next;
    logic [tps_pkg::CFG_DATA_W-1:0] den_reg, den_next;
    logic [tps_pkg::COORD_W-1:0]    den_eff;
    tps_pkg::weights_t              weights;

    // Front to queue, queue to back
    logic           push_valid, push_ready;
    tps_pkg::item_t push_item;
    logic           pop_valid, pop_ready;
    tps_pkg::item_t pop_item;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                tps_pkg::REG_SMOOTHING_NUM: num_next = cfg_ch.data;
                tps_pkg::REG_SMOOTHING_DEN: den_next = cfg_ch.data;
                default:
                begin
                    num_next = num_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            den_reg <= tps_pkg::CFG_DATA_W'(1);
        end
        else
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // Zero denominator acts as one; numerator clamps to the denominator
    assign den_eff     = (den_reg == '0) ? tps_pkg::COORD_W'(1) : den_reg;
    assign weights.den = den_eff;
    assign weights.num = (num_reg > den_eff) ? den_eff : num_reg;

    tps_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_slot         (in_ch.slot),
        .in_x            (in_ch.x_in),
        .in_y            (in_ch.y_in),
        .in_pressure     (in_ch.pressure_in),
        .in_sample_valid (in_ch.sample_valid),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    tps_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tps_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .weights          (weights),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_slot         (out_ch.slot_out),
        .out_x            (out_ch.x_out),
        .out_y            (out_ch.y_out),
        .out_pressure     (out_ch.pressure_out),
        .out_sample_valid (out_ch.valid_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/tps_check.sv */
`default_nettype none

module tps_check (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [tps_pkg::COORD_W-1:0]   out_x,
    input wire logic [tps_pkg::COORD_W-1:0]   out_y,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its coordinates
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y))
        else $error("result changed while stalled");

    // No result in the cycle after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered right after reset");

    // Register writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind touch_point_iir_smoother_core tps_check u_tps_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.x_out),
    .out_y     (out_ch.y_out),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready)
);

`default_nettype wire
